// ----- hdl/tclt_pkg.sv -----
// Shared types, codes and constants of the tunnel client learning table.
package tclt_pkg;

  localparam int TableDepthDefault = 16;
  localparam int MaxResults = 16;
  localparam int CountW = $clog2(MaxResults + 1);
  localparam logic [15:0] DefaultTimeout = 16'd30;
  localparam logic [31:0] DefaultMask = 32'hFFFF_FF00;

  // Event codes.
  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_HEARTBEAT = 3'd1;
  localparam logic [2:0] ACT_LOCAL_IP = 3'd2;
  localparam logic [2:0] ACT_FWD_IP = 3'd3;
  localparam logic [2:0] ACT_LOCAL_ARP = 3'd4;
  localparam logic [2:0] ACT_FWD_ARP = 3'd5;

  // Decision codes.
  localparam logic [2:0] DEC_DROP = 3'd0;
  localparam logic [2:0] DEC_LOCAL = 3'd1;
  localparam logic [2:0] DEC_CLIENT = 3'd2;
  localparam logic [2:0] DEC_SERVER = 3'd3;
  localparam logic [2:0] DEC_UPDATED = 3'd4;
  localparam logic [2:0] DEC_ADDED = 3'd5;
  localparam logic [2:0] DEC_FULL = 3'd6;
  localparam logic [2:0] DEC_EXPIRED = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROLE = 3'd0;
  localparam logic [2:0] REG_OWN_IP = 3'd1;
  localparam logic [2:0] REG_SUBNET_MASK = 3'd2;
  localparam logic [2:0] REG_OWN_MAC = 3'd3;
  localparam logic [2:0] REG_AUTH_CRC = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] packet_crc;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] dest_ip;
    logic [7:0]  peer_handle;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  decision;
    logic [3:0]  client_slot;
    logic [7:0]  out_peer;
    logic [15:0] out_echo_id;
    logic [15:0] out_echo_seq;
    logic [31:0] hdr_ip;
    logic [47:0] hdr_mac;
    logic        last;
  } rsp_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] seq;
    logic [31:0] seen;
    logic [7:0]  peer;
  } entry_t;

  typedef enum logic [2:0] {
    K_NONE, K_TICK, K_HB, K_FIRST, K_ALL
  } kind_t;

  typedef enum logic [1:0] {
    H_ENTRY, H_INPUT, H_OWN
  } hdr_src_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_READ, S_EVAL, S_COMMIT, S_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic eval_go;
    logic commit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic dec_none;
    logic kind_hb;
    logic emit;
    logic can_push;
    logic scan_end;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/tunnel_client_learning_table.sv -----
// Top level of the tunnel client learning table.
//
// This block makes the forwarding decision for an echo-based tunnel. Each request word
// carries one packet event; the block answers with one or more result words, the final
// one marked by last. In server mode it keeps a table of TABLE_DEPTH clients learned
// from authenticated heartbeats and ages them out on tick events. Events are handled
// one at a time: after a request word is taken, a decode state follows, and an event
// that consults the table then scans it slot by slot (address, then registered table
// read); a heartbeat adds a table write after the scan. An event that needs no table
// lookup goes from decode straight to the result flush. The scan is the rate-setting
// loop, bounded by the single read port of the table memory. Result words sit in an
// output register, so a stalled consumer only holds the scan at the next match. Up to
// 16 matches or expiries are reported per event; remaining expired clients leave on a
// later tick. Configuration words may be written at any time the block is idle; the
// write port is always ready. The table needs no clearing pass after reset because
// each slot has its own valid bit.
module tunnel_client_learning_table #(
  parameter int TABLE_DEPTH = tclt_pkg::TableDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tclt_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tclt_pkg::rsp_word_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  import tclt_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Configuration registers accept a word in every cycle.
  assign cfg_ready = 1'b1;

  tclt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tclt_dp #(.DEPTH(TABLE_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .req      (req),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

// ----- hdl/tclt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tclt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tclt_ctrl.sv -----
// Sequencing state machine of the tunnel client learning table.
module tclt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  tclt_pkg::status_t st,
  output tclt_pkg::cmd_t    cmd
);
  import tclt_pkg::*;

  state_t state, state_next;
  logic go;

  assign go = (state == S_EVAL) && (!st.emit || st.can_push);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = st.dec_none ? S_FLUSH : S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (go) begin
          if (!st.scan_end) state_next = S_READ;
          else if (st.kind_hb) state_next = S_COMMIT;
          else state_next = S_FLUSH;
        end
      end
      S_COMMIT: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = (state == S_IDLE);
    cmd         = '0;
    cmd.load    = (state == S_IDLE) && req_valid;
    cmd.decode  = (state == S_DECODE);
    cmd.eval_go = go;
    cmd.commit  = (state == S_COMMIT);
    cmd.flush   = (state == S_FLUSH) && st.out_free;
  end

endmodule

// ----- hdl/tclt_dp.sv -----
// Datapath: registers, client table, slot scan logic and result registers.
module tclt_dp #(
  parameter int DEPTH = tclt_pkg::TableDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  tclt_pkg::cmd_t      cmd,
  output tclt_pkg::status_t   st,
  input  tclt_pkg::req_word_t req,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tclt_pkg::rsp_word_t rsp
);
  import tclt_pkg::*;

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = $bits(entry_t);
  localparam logic [SW-1:0] LastSlot = SW'(DEPTH - 1);

  logic        srv_en;
  logic [31:0] own_ip, subnet_mask, auth_crc;
  logic [47:0] own_mac;
  logic [15:0] timeout_secs;

  req_word_t   item;
  logic [31:0] now_secs;
  logic [DEPTH-1:0] valid;
  kind_t       kind, dec_kind;
  hdr_src_t    src, dec_src;
  rsp_word_t   pend, dec_pend, new_res, push_word, hb_res;
  logic        pend_v, dec_pend_v, push;
  logic [SW-1:0] slot, hit_slot, free_slot, hb_slot;
  logic        hit_v, free_v;
  logic [CountW-1:0] n;
  logic [EW-1:0] rdata;
  entry_t      ent, wr_ent;
  logic        vhit, emit, key_bad;
  logic [SW+3:0] slot_wide;
  logic [SW+3:0] hb_wide;

  tclt_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_table (
    .clk  (clk),
    .we   (cmd.commit && (hit_v || free_v)),
    .waddr(hb_slot),
    .wdata(wr_ent),
    .raddr(slot),
    .rdata(rdata)
  );

  assign ent       = entry_t'(rdata);
  assign vhit      = valid[slot];
  assign slot_wide = {4'b0, slot};
  assign hb_slot   = hit_v ? hit_slot : free_slot;
  assign hb_wide   = {4'b0, hb_slot};
  assign wr_ent    = '{id: item.echo_id, ip: item.src_ip, mac: item.src_mac,
                       seq: item.echo_seq, seen: now_secs, peer: item.peer_handle};

  // Event decode: what kind of scan, or a result that needs no scan.
  always_comb begin
    dec_kind   = K_NONE;
    dec_src    = H_ENTRY;
    dec_pend_v = 1'b0;
    dec_pend   = '0;
    key_bad    = ((item.action == ACT_HEARTBEAT) || (item.action == ACT_FWD_IP) ||
                  (item.action == ACT_FWD_ARP)) && (item.packet_crc != auth_crc);
    if (!key_bad) begin
      case (item.action)
        ACT_TICK: begin
          if (srv_en) dec_kind = K_TICK;
        end
        ACT_HEARTBEAT: begin
          if (srv_en) dec_kind = K_HB;
        end
        ACT_LOCAL_IP: begin
          if (!srv_en) begin
            dec_pend_v        = 1'b1;
            dec_pend.decision = DEC_SERVER;
            dec_pend.hdr_ip   = item.src_ip;
            dec_pend.hdr_mac  = item.src_mac;
          end else if ((item.dest_ip & subnet_mask) == (own_ip & subnet_mask)) begin
            dec_kind = K_FIRST;
          end
        end
        ACT_FWD_IP: begin
          if (item.dest_ip == own_ip) begin
            dec_pend_v        = 1'b1;
            dec_pend.decision = DEC_LOCAL;
          end else if (srv_en) begin
            dec_kind = K_FIRST;
            dec_src  = H_INPUT;
          end
        end
        ACT_LOCAL_ARP: begin
          if (!srv_en) begin
            dec_pend_v        = 1'b1;
            dec_pend.decision = DEC_SERVER;
            dec_pend.hdr_mac  = item.src_mac;
          end else begin
            dec_kind = K_ALL;
            dec_src  = H_OWN;
          end
        end
        ACT_FWD_ARP: begin
          if (item.dest_ip == own_ip) begin
            dec_pend_v        = 1'b1;
            dec_pend.decision = DEC_LOCAL;
          end else if (srv_en) begin
            dec_kind = K_ALL;
            dec_src  = H_INPUT;
          end
        end
        default: begin
          dec_kind = K_NONE;
        end
      endcase
    end
  end

  // Per-slot evaluation of the entry read out of the table.
  always_comb begin
    case (kind)
      K_TICK:  emit = vhit && ((now_secs - ent.seen) > {16'b0, timeout_secs}) &&
                      (n < CountW'(MaxResults));
      K_FIRST, K_ALL:
               emit = vhit && (ent.ip == item.dest_ip) && (n < CountW'(MaxResults));
      default: emit = 1'b0;
    endcase
    new_res              = '0;
    new_res.decision     = (kind == K_TICK) ? DEC_EXPIRED : DEC_CLIENT;
    new_res.client_slot  = slot_wide[3:0];
    new_res.out_peer     = ent.peer;
    new_res.out_echo_id  = ent.id;
    new_res.out_echo_seq = ent.seq;
    case (src)
      H_INPUT: begin
        new_res.hdr_ip  = item.src_ip;
        new_res.hdr_mac = item.src_mac;
      end
      H_OWN: begin
        new_res.hdr_ip  = own_ip;
        new_res.hdr_mac = own_mac;
      end
      default: begin
        new_res.hdr_ip  = ent.ip;
        new_res.hdr_mac = ent.mac;
      end
    endcase
  end

  // Heartbeat outcome: the entry as written, or a full report.
  always_comb begin
    hb_res = '0;
    if (hit_v || free_v) begin
      hb_res.decision     = hit_v ? DEC_UPDATED : DEC_ADDED;
      hb_res.client_slot  = hb_wide[3:0];
      hb_res.out_peer     = item.peer_handle;
      hb_res.out_echo_id  = item.echo_id;
      hb_res.out_echo_seq = item.echo_seq;
      hb_res.hdr_ip       = item.src_ip;
      hb_res.hdr_mac      = item.src_mac;
    end else begin
      hb_res.decision = DEC_FULL;
    end
  end

  always_comb begin
    st.dec_none = (dec_kind == K_NONE);
    st.kind_hb  = (kind == K_HB);
    st.emit     = emit;
    st.out_free = !rsp_valid || rsp_ready;
    st.can_push = !pend_v || st.out_free;
    st.scan_end = (slot == LastSlot) || ((kind == K_FIRST) && emit);
  end

  // A held result goes out when a newer one displaces it, or at the final flush.
  always_comb begin
    push      = (cmd.eval_go && emit && pend_v) || cmd.flush;
    push_word = pend;
    if (cmd.flush) begin
      if (!pend_v) push_word = '0;
      push_word.last = 1'b1;
    end else begin
      push_word.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srv_en       <= 1'b1;
      own_ip       <= '0;
      subnet_mask  <= DefaultMask;
      own_mac      <= '0;
      auth_crc     <= '0;
      timeout_secs <= DefaultTimeout;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROLE:        srv_en       <= cfg_data[0];
        REG_OWN_IP:      own_ip       <= cfg_data[31:0];
        REG_SUBNET_MASK: subnet_mask  <= cfg_data[31:0];
        REG_OWN_MAC:     own_mac      <= cfg_data;
        REG_AUTH_CRC:    auth_crc     <= cfg_data[31:0];
        REG_TIMEOUT:     timeout_secs <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
    if (cmd.decode) begin
      src  <= dec_src;
    end
    if (push) rsp <= push_word;
    if (cmd.eval_go && emit) pend <= new_res;
    if (cmd.decode) pend <= dec_pend;
    if (cmd.commit) pend <= hb_res;
    if (cmd.eval_go && (kind == K_HB)) begin
      if (vhit && !hit_v && (ent.id == item.echo_id)) hit_slot <= slot;
      if (!vhit && !free_v) free_slot <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_secs  <= '0;
      valid     <= '0;
      kind      <= K_NONE;
      pend_v    <= 1'b0;
      rsp_valid <= 1'b0;
      slot      <= '0;
      n         <= '0;
      hit_v     <= 1'b0;
      free_v    <= 1'b0;
    end else begin
      if (push) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (cmd.decode) begin
        kind   <= dec_kind;
        pend_v <= dec_pend_v;
        slot   <= '0;
        n      <= '0;
        hit_v  <= 1'b0;
        free_v <= 1'b0;
        if (item.action == ACT_TICK) now_secs <= now_secs + 32'd1;
      end
      if (cmd.eval_go) begin
        slot <= slot + SW'(1);
        if (emit) begin
          n      <= n + CountW'(1);
          pend_v <= 1'b1;
          if (kind == K_TICK) valid[slot] <= 1'b0;
        end
        if (kind == K_HB) begin
          if (vhit && (ent.id == item.echo_id)) hit_v <= 1'b1;
          if (!vhit) free_v <= 1'b1;
        end
      end
      if (cmd.commit) begin
        pend_v <= 1'b1;
        if (hit_v || free_v) valid[hb_slot] <= 1'b1;
      end
      if (cmd.flush) pend_v <= 1'b0;
    end
  end

  a_commit_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !pend_v) else $error("commit with a result still held");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !pend_v) else $error("held result survived the flush");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CountW'(MaxResults)) else $error("result count beyond limit");
  a_valid_stable: assert property (@(posedge clk) disable iff (rst)
    (!cmd.commit && !cmd.eval_go) |=> $stable(valid))
    else $error("valid bits changed outside a scan or commit");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> (!rsp_valid || rsp_ready)) else $error("result word overwritten");

endmodule

// ----- tb/sv/tclt_checker.sv -----
// Checker for the tunnel client learning table: predicts result words and compares them.
`timescale 1ns / 100ps
module tclt_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  tclt_pkg::req_word_t req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  tclt_pkg::rsp_word_t rsp,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  words_seen
);
  import tclt_pkg::*;

  // A failed key check is handled like an unknown event.
  localparam logic [2:0] ActKeyFail = 3'd6;

  // Configuration copy.
  logic        mode_srv;
  logic [31:0] my_ip;
  logic [31:0] my_mask;
  logic [47:0] my_mac;
  logic [31:0] key_crc;
  logic [15:0] idle_limit;

  // Client table copy.
  logic        tv[16];
  entry_t      te[16];
  logic [31:0] clock_secs;

  rsp_word_t decisions_due[$];

  function automatic rsp_word_t mk(logic [2:0] d, logic [3:0] s, logic [7:0] p,
                                   logic [15:0] id, logic [15:0] sq,
                                   logic [31:0] ip, logic [47:0] mac);
    rsp_word_t r;
    r.decision = d; r.client_slot = s; r.out_peer = p; r.out_echo_id = id;
    r.out_echo_seq = sq; r.hdr_ip = ip; r.hdr_mac = mac; r.last = 1'b0;
    return r;
  endfunction

  task automatic forward_event(input req_word_t w);
    logic [2:0] act;
    logic [2:0] hb_dec;
    int n;
    int hit;
    int freeslot;
    logic [31:0] hip;
    logic [47:0] hmac;
    rsp_word_t r;
    act = w.action;
    n = 0;
    if ((act == ACT_HEARTBEAT || act == ACT_FWD_IP || act == ACT_FWD_ARP) &&
        w.packet_crc != key_crc)
      act = ActKeyFail;
    case (act)
      ACT_TICK: begin
        clock_secs = clock_secs + 32'd1;
        if (mode_srv) begin
          for (int s = 0; s < 16 && n < MaxResults; s++) begin
            if (tv[s] && (clock_secs - te[s].seen) > {16'd0, idle_limit}) begin
              tv[s] = 1'b0;
              decisions_due.push_back(mk(DEC_EXPIRED, 4'(s), te[s].peer, te[s].id,
                                         te[s].seq, te[s].ip, te[s].mac));
              n++;
            end
          end
        end
      end
      ACT_HEARTBEAT: begin
        if (mode_srv) begin
          hit = -1; freeslot = -1;
          for (int s = 0; s < 16; s++) begin
            if (tv[s]) begin
              if (hit < 0 && te[s].id == w.echo_id) hit = s;
            end else if (freeslot < 0) begin
              freeslot = s;
            end
          end
          if (hit < 0 && freeslot < 0) begin
            decisions_due.push_back(mk(DEC_FULL, '0, '0, '0, '0, '0, '0));
          end else begin
            hb_dec = (hit < 0) ? DEC_ADDED : DEC_UPDATED;
            if (hit < 0) hit = freeslot;
            tv[hit] = 1'b1;
            te[hit] = '{id: w.echo_id, ip: w.src_ip, mac: w.src_mac, seq: w.echo_seq,
                        seen: clock_secs, peer: w.peer_handle};
            decisions_due.push_back(mk(hb_dec, 4'(hit), w.peer_handle, w.echo_id,
                                       w.echo_seq, w.src_ip, w.src_mac));
          end
          n++;
        end
      end
      ACT_LOCAL_IP: begin
        if (!mode_srv) begin
          decisions_due.push_back(mk(DEC_SERVER, '0, '0, '0, '0, w.src_ip, w.src_mac));
          n++;
        end else if ((w.dest_ip & my_mask) == (my_ip & my_mask)) begin
          for (int s = 0; s < 16 && n == 0; s++) begin
            if (tv[s] && te[s].ip == w.dest_ip) begin
              decisions_due.push_back(mk(DEC_CLIENT, 4'(s), te[s].peer, te[s].id,
                                         te[s].seq, te[s].ip, te[s].mac));
              n++;
            end
          end
        end
      end
      ACT_FWD_IP: begin
        if (w.dest_ip == my_ip) begin
          decisions_due.push_back(mk(DEC_LOCAL, '0, '0, '0, '0, '0, '0));
          n++;
        end else if (mode_srv) begin
          for (int s = 0; s < 16 && n == 0; s++) begin
            if (tv[s] && te[s].ip == w.dest_ip) begin
              decisions_due.push_back(mk(DEC_CLIENT, 4'(s), te[s].peer, te[s].id,
                                         te[s].seq, w.src_ip, w.src_mac));
              n++;
            end
          end
        end
      end
      ACT_LOCAL_ARP, ACT_FWD_ARP: begin
        if (act == ACT_LOCAL_ARP && !mode_srv) begin
          decisions_due.push_back(mk(DEC_SERVER, '0, '0, '0, '0, '0, w.src_mac));
          n++;
        end else if (act == ACT_FWD_ARP && w.dest_ip == my_ip) begin
          decisions_due.push_back(mk(DEC_LOCAL, '0, '0, '0, '0, '0, '0));
          n++;
        end else if (mode_srv) begin
          hip = (act == ACT_LOCAL_ARP) ? my_ip : w.src_ip;
          hmac = (act == ACT_LOCAL_ARP) ? my_mac : w.src_mac;
          for (int s = 0; s < 16 && n < MaxResults; s++) begin
            if (tv[s] && te[s].ip == w.dest_ip) begin
              decisions_due.push_back(mk(DEC_CLIENT, 4'(s), te[s].peer, te[s].id,
                                         te[s].seq, hip, hmac));
              n++;
            end
          end
        end
      end
      default: ;
    endcase
    if (n == 0) decisions_due.push_back(mk(DEC_DROP, '0, '0, '0, '0, '0, '0));
    r = decisions_due.pop_back();
    r.last = 1'b1;
    decisions_due.push_back(r);
  endtask

  always @(posedge clk) begin
    rsp_word_t e;
    if (rst) begin
      mode_srv <= 1'b1; my_ip <= '0; my_mask <= DefaultMask; my_mac <= '0;
      key_crc <= '0; idle_limit <= DefaultTimeout;
      clock_secs = '0;
      for (int s = 0; s < 16; s++) tv[s] = 1'b0;
      decisions_due.delete();
      fail_count <= 0;
      words_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROLE:        mode_srv <= cfg_data[0];
          REG_OWN_IP:      my_ip <= cfg_data[31:0];
          REG_SUBNET_MASK: my_mask <= cfg_data[31:0];
          REG_OWN_MAC:     my_mac <= cfg_data;
          REG_AUTH_CRC:    key_crc <= cfg_data[31:0];
          REG_TIMEOUT:     idle_limit <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) forward_event(req);
      if (rsp_valid && rsp_ready) begin
        words_seen <= words_seen + 1;
        if (decisions_due.size() == 0) begin
          $error("unexpected result word %p", rsp);
          fail_count <= fail_count + 1;
        end else begin
          e = decisions_due.pop_front();
          if (rsp !== e) begin
            if (rsp.decision !== e.decision)
              $error("decision exp %0d got %0d", e.decision, rsp.decision);
            if (rsp.client_slot !== e.client_slot)
              $error("client_slot exp %0d got %0d", e.client_slot, rsp.client_slot);
            if (rsp.out_peer !== e.out_peer)
              $error("out_peer exp %0h got %0h", e.out_peer, rsp.out_peer);
            if (rsp.out_echo_id !== e.out_echo_id)
              $error("out_echo_id exp %0h got %0h", e.out_echo_id, rsp.out_echo_id);
            if (rsp.out_echo_seq !== e.out_echo_seq)
              $error("out_echo_seq exp %0h got %0h", e.out_echo_seq, rsp.out_echo_seq);
            if (rsp.hdr_ip !== e.hdr_ip)
              $error("hdr_ip exp %0h got %0h", e.hdr_ip, rsp.hdr_ip);
            if (rsp.hdr_mac !== e.hdr_mac)
              $error("hdr_mac exp %0h got %0h", e.hdr_mac, rsp.hdr_mac);
            if (rsp.last !== e.last)
              $error("last exp %0d got %0d", e.last, rsp.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // Blocking updates of the queue make its size current right after the edge.
  assign pending = decisions_due.size();

endmodule

// ----- tb/sv/tb_tunnel_client_learning_table.sv -----
// Testbench top for the tunnel client learning table: stimulus, pacing and verdict.
`timescale 1ns / 100ps
module tb_tunnel_client_learning_table;
  import tclt_pkg::*;

  // An event code the block does not know.
  localparam logic [2:0] ActUnknown = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_word_t   req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_word_t   rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          words_seen;
  int          idle_cycles = 0;
  int          events_sent = 0;
  int          phase_now = -1;
  // Receiver stall controls: a long hold-off runs in its own process.
  logic        hold_off = 1'b0;
  logic [31:0] ip_pool[4];

  always #10 clk = ~clk;

  tunnel_client_learning_table u_top (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tclt_checker u_chk (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending, .words_seen
  );

  // Receiver: random stall pattern with calm stretches, plus the long hold-off.
  always @(negedge clk) begin
    if (hold_off) begin
      rsp_ready <= 1'b0;
    end else if (words_seen % 64 < 20) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Long hold-off in the second random phase while the sender keeps offering words.
  initial begin
    wait (phase_now == 1);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (300) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: the run ends if nothing is accepted for too long.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready) ||
        rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Writes one configuration register; the caller makes sure the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offers one event word and holds it until taken; random gap before it.
  task automatic send_word(input req_word_t w, input int gap);
    repeat (gap + 1) @(negedge clk);
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    req_valid <= 1'b0;
    events_sent++;
  endtask

  task automatic settle;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Builds a random event; keys mostly match and addresses come from a small pool.
  function automatic req_word_t rand_event(input logic [31:0] key);
    req_word_t w;
    w.action = $urandom_range(0, 9) < 8 ? 3'($urandom_range(0, 5)) : 3'($urandom_range(0, 7));
    w.packet_crc = ($urandom_range(0, 9) == 0) ? $urandom : key;
    w.echo_id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
    w.echo_seq = 16'($urandom);
    w.src_ip = ip_pool[$urandom_range(0, 3)];
    w.src_mac = {16'($urandom), 32'($urandom)};
    w.dest_ip = ($urandom_range(0, 4) == 0) ? $urandom : ip_pool[$urandom_range(0, 3)];
    w.peer_handle = 8'($urandom);
    return w;
  endfunction

  function automatic req_word_t ev(input logic [2:0] a, input logic [31:0] key,
                                   input logic [15:0] id, input logic [31:0] sip,
                                   input logic [31:0] dip);
    req_word_t w;
    w = '{action: a, packet_crc: key, echo_id: id, echo_seq: 16'($urandom), src_ip: sip,
          src_mac: {16'($urandom), 32'($urandom)}, dest_ip: dip,
          peer_handle: 8'($urandom)};
    return w;
  endfunction

  initial begin
    logic [31:0] key;
    int burst;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    ip_pool = '{32'h0A00_0005, 32'h0A00_0007, 32'h0A00_00FF, 32'h0B00_0001};

    // Directed part, reset configuration, server mode with a zero key.
    send_word(ev(ACT_TICK, 0, 16'd0, 0, 0), 0);
    send_word(ev(ACT_HEARTBEAT, 32'h1, 16'd1, 0, 0), 0);     // wrong key
    for (int i = 0; i < 17; i++)                               // fill, then full
      send_word(ev(ACT_HEARTBEAT, 0, 16'(i), ip_pool[i % 2], 0), $urandom_range(0, 2));
    send_word(ev(ACT_HEARTBEAT, 0, 16'hFFFF, 32'hFFFF_FFFF, 0), 0);
    send_word(ev(ACT_HEARTBEAT, 0, 16'd3, ip_pool[0], 0), 0);  // update
    send_word(ev(ACT_LOCAL_ARP, 0, 16'd0, 0, ip_pool[0]), 0);  // many matches
    send_word(ev(ACT_FWD_ARP, 0, 16'd0, 32'hFFFF_FFFF, ip_pool[1]), 0);
    send_word(ev(ACT_FWD_ARP, 0, 16'd0, 0, 0), 0);             // own address
    send_word(ev(ACT_LOCAL_IP, 0, 16'd0, 0, ip_pool[1]), 0);
    send_word(ev(ACT_FWD_IP, 0, 16'd0, 0, ip_pool[0]), 0);
    send_word(ev(ACT_FWD_IP, 0, 16'd0, 0, 0), 0);
    send_word(ev(ActUnknown, 0, 16'd0, 0, 0), 0);
    settle();

    // Zero timeout: every client ages out on the first tick in one full batch; the second tick finds none left.
    write_reg(REG_TIMEOUT, 48'd0);
    write_reg(REG_OWN_IP, 48'h0A00_0001);
    send_word(ev(ACT_TICK, 0, 16'd0, 0, 0), 0);
    send_word(ev(ACT_TICK, 0, 16'd0, 0, 0), 0);
    settle();

    // Random phases under several settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      key = (ph == 5) ? 32'hFFFF_FFFF : $urandom;
      write_reg(REG_AUTH_CRC, {16'd0, key});
      write_reg(REG_ROLE, (ph == 2) ? 48'd0 : 48'd1);
      write_reg(REG_SUBNET_MASK, (ph == 3) ? 48'd0 : (ph == 5) ? 48'hFFFF_FFFF :
                {16'd0, 32'hFFFF_FF00});
      write_reg(REG_OWN_MAC, (ph % 2) ? 48'hFFFF_FFFF_FFFF : {16'($urandom), 32'($urandom)});
      write_reg(REG_TIMEOUT, (ph == 4) ? 48'hFFFF : 48'($urandom_range(1, 4)));
      write_reg(REG_OWN_IP, (ph == 5) ? 48'hFFFF_FFFF : 48'h0A00_0001);
      phase_now = ph;
      for (int i = 0; i < 25; i++) begin
        burst = $urandom_range(0, 3);
        send_word(rand_event(key), (burst == 0) ? $urandom_range(1, 30) : 0);
      end
      settle();
    end

    $display("Sent %0d event words and checked %0d result words across six settings.",
             events_sent, words_seen);
    $display("Covered all event kinds, key failures, table full, aging and multi-match ARP.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tclt_pkg.sv
hdl/tclt_ram.sv
hdl/tclt_ctrl.sv
hdl/tclt_dp.sv
hdl/tunnel_client_learning_table.sv
tb/sv/tclt_checker.sv
tb/sv/tb_tunnel_client_learning_table.sv
